// ----- rtl/core/mrh_pkg.sv -----
// Shared constants, types and state codes for the masked region histogram.
package mrh_pkg;

  // Sizing
  localparam int MAX_BINS   = 64;
  localparam int COUNT_BITS = 21;
  localparam int LABEL_BITS = 16;

  // Fixed field widths
  localparam int VALUE_W     = 8;
  localparam int LABEL_W     = 16;
  localparam int NUM_BINS_W  = 7;
  localparam int RANGE_W     = 8;
  localparam int OUT_IDX_W   = 6;
  localparam int FRAC_BITS   = 16;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Derived widths
  localparam int BIN_BITS   = $clog2(MAX_BINS);
  localparam int NB_BITS    = $clog2(MAX_BINS + 1);
  localparam int REM_W      = VALUE_W + NB_BITS;
  localparam int LABEL_CMP  = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
  localparam int FRAC_STEPS = FRAC_W;
  localparam int STEP_W     = $clog2(FRAC_STEPS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Register reset values
  localparam logic [NUM_BINS_W-1:0] NUM_BINS_RST     = NUM_BINS_W'(25);
  localparam logic [RANGE_W-1:0]    RANGE_MAX_RST    = RANGE_W'(180);
  localparam logic [LABEL_W-1:0]    TARGET_LABEL_RST = LABEL_W'(1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LABEL = CFG_IDX_W'(2);

  // Item kinds
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_PIX,
    ST_DRAIN,
    ST_RD,
    ST_LOAD,
    ST_DIV,
    ST_OUT,
    ST_CLR
  } state_t;

  // Bin update request from the binning pipeline
  typedef struct packed {
    logic                vld;
    logic [BIN_BITS-1:0] idx;
  } bin_req_t;

  // Fraction divider result
  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quot;
  } frac_res_t;

endpackage

// ----- rtl/core/mrh_ram.sv -----
// Generic simple dual-port RAM with registered read (read returns old data).
module mrh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/mrh_bin_pipe.sv -----
// Pixel qualification, total counter and pipelined bin select.
module mrh_bin_pipe (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pix_fire,
  input  logic [mrh_pkg::VALUE_W-1:0]     pixel_value,
  input  logic [mrh_pkg::LABEL_W-1:0]     pixel_label,
  input  logic [mrh_pkg::NB_BITS-1:0]     n_eff,
  input  logic [mrh_pkg::RANGE_W-1:0]     range_max,
  input  logic [mrh_pkg::LABEL_W-1:0]     target_label,
  input  logic                            total_clr,
  output mrh_pkg::bin_req_t               req,
  output logic                            busy,
  output logic [mrh_pkg::COUNT_BITS-1:0]  total
);

  logic                             vld_r [0:mrh_pkg::BIN_BITS];
  logic [mrh_pkg::REM_W-1:0]        rem_r [0:mrh_pkg::BIN_BITS];
  logic [mrh_pkg::BIN_BITS-1:0]     q_r   [0:mrh_pkg::BIN_BITS];
  logic [mrh_pkg::REM_W-1:0]        dvs   [0:mrh_pkg::BIN_BITS-1];
  logic                             ge    [0:mrh_pkg::BIN_BITS-1];
  logic [mrh_pkg::COUNT_BITS-1:0]   total_r;
  logic [mrh_pkg::COUNT_BITS-1:0]   total_nxt;
  logic                             take;
  logic [mrh_pkg::REM_W-1:0]        prod;
  logic [mrh_pkg::REM_W-1:0]        x;

  always_comb begin
    take = pix_fire
        && (pixel_label[mrh_pkg::LABEL_CMP-1:0] == target_label[mrh_pkg::LABEL_CMP-1:0])
        && (pixel_value <= range_max)
        && (total_r != mrh_pkg::COUNT_MAX);
    // bin = floor((v*n - 1) / r), value zero goes to bin 0
    prod = mrh_pkg::REM_W'(pixel_value) * mrh_pkg::REM_W'(n_eff);
    x    = (pixel_value == '0) ? '0 : prod - mrh_pkg::REM_W'(1);
    if (total_clr) begin
      total_nxt = '0;
    end else if (take) begin
      total_nxt = total_r + mrh_pkg::COUNT_BITS'(1);
    end else begin
      total_nxt = total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int k = 0; k <= mrh_pkg::BIN_BITS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      total_r  <= total_nxt;
      vld_r[0] <= take;
      for (int k = 0; k < mrh_pkg::BIN_BITS; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  // One quotient bit per stage, MSB first. Since v <= r, quotient < n.
  // Zero range only lets value 0 through, which stays in bin 0.
  always_comb begin
    for (int k = 0; k < mrh_pkg::BIN_BITS; k++) begin
      dvs[k] = mrh_pkg::REM_W'(range_max) << (mrh_pkg::BIN_BITS - 1 - k);
      ge[k]  = (range_max != '0) && (rem_r[k] >= dvs[k]);
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= x;
    q_r[0]   <= '0;
    for (int k = 0; k < mrh_pkg::BIN_BITS; k++) begin
      rem_r[k+1] <= ge[k] ? rem_r[k] - dvs[k] : rem_r[k];
      q_r[k+1]   <= q_r[k] | (ge[k] ? (mrh_pkg::BIN_BITS'(1) << (mrh_pkg::BIN_BITS - 1 - k))
                                    : '0);
    end
  end

  always_comb begin
    busy = 1'b0;
    for (int k = 0; k <= mrh_pkg::BIN_BITS; k++) begin
      busy = busy | vld_r[k];
    end
    req.vld = vld_r[mrh_pkg::BIN_BITS];
    req.idx = q_r[mrh_pkg::BIN_BITS];
    total   = total_r;
  end

endmodule

// ----- rtl/core/mrh_frac_div.sv -----
// Iterative restoring divider: floor(count * 2^16 / total), one bit per cycle.
module mrh_frac_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mrh_pkg::COUNT_BITS-1:0] dividend,
  input  logic [mrh_pkg::COUNT_BITS-1:0] divisor,
  output mrh_pkg::frac_res_t             res
);

  logic                           busy_r;
  logic                           done_r;
  logic [mrh_pkg::STEP_W-1:0]     cnt_r;
  logic [mrh_pkg::COUNT_BITS:0]   rem_r;
  logic [mrh_pkg::FRAC_W-1:0]     q_r;
  logic [mrh_pkg::COUNT_BITS:0]   dvs;
  logic                           ge;
  logic [mrh_pkg::COUNT_BITS:0]   rem_sub;

  always_comb begin
    dvs     = (mrh_pkg::COUNT_BITS + 1)'(divisor);
    ge      = rem_r >= dvs;
    rem_sub = ge ? rem_r - dvs : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + mrh_pkg::STEP_W'(1);
        if (cnt_r == mrh_pkg::STEP_W'(mrh_pkg::FRAC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // count <= total, so the remainder stays below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (mrh_pkg::COUNT_BITS + 1)'(dividend);
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= {rem_sub[mrh_pkg::COUNT_BITS-1:0], 1'b0};
      q_r   <= {q_r[mrh_pkg::FRAC_W-2:0], ge};
    end
  end

  assign res.done = done_r;
  assign res.quot = q_r;

endmodule

// ----- rtl/core/masked_region_histogram.sv -----
// Masked region histogram top level: config, bin store, result sequencer.
// Pixels: one accepted per cycle while in pixel mode; a counted pixel passes the
//   bin-select stages and the read-modify-write stage (with forwarding) before it reaches the bin store.
// Finish: drains the pipeline, then per bin in use reads and clears the entry and runs
//   one 17-step divide (skipped when nothing was counted), plus result stalls, then
//   clears the store entries beyond the bins in use.
// Reset (synchronous, rst_n low) clears control and the total; the whole store is
//   then swept to zero before the first pixel is taken.
module masked_region_histogram (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel / finish channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [mrh_pkg::VALUE_W-1:0]       in_pixel_value,
  input  logic [mrh_pkg::LABEL_W-1:0]       in_pixel_label,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mrh_pkg::OUT_IDX_W-1:0]     out_bin_index,
  output logic [mrh_pkg::FRAC_W-1:0]        out_fraction,
  output logic                              out_empty_res,
  output logic                              out_last,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mrh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrh_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // ---------------------------------------------------------------
  // Configuration registers, always writable
  // ---------------------------------------------------------------
  logic [mrh_pkg::NUM_BINS_W-1:0] num_bins_r;
  logic [mrh_pkg::RANGE_W-1:0]    range_max_r;
  logic [mrh_pkg::LABEL_W-1:0]    target_label_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r     <= mrh_pkg::NUM_BINS_RST;
      range_max_r    <= mrh_pkg::RANGE_MAX_RST;
      target_label_r <= mrh_pkg::TARGET_LABEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mrh_pkg::CFG_NUM_BINS: begin
          num_bins_r <= cfg_data[mrh_pkg::NUM_BINS_W-1:0];
        end
        mrh_pkg::CFG_RANGE_MAX: begin
          range_max_r <= cfg_data[mrh_pkg::RANGE_W-1:0];
        end
        mrh_pkg::CFG_TARGET_LABEL: begin
          target_label_r <= cfg_data[mrh_pkg::LABEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Bins in use: zero means one, saturate at MAX_BINS
  logic [mrh_pkg::NB_BITS-1:0] n_eff;

  always_comb begin
    if (num_bins_r == '0) begin
      n_eff = mrh_pkg::NB_BITS'(1);
    end else if (32'(num_bins_r) > mrh_pkg::MAX_BINS) begin
      n_eff = mrh_pkg::NB_BITS'(mrh_pkg::MAX_BINS);
    end else begin
      n_eff = mrh_pkg::NB_BITS'(num_bins_r);
    end
  end

  // ---------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------
  mrh_pkg::state_t                 state_r, state_nxt;
  logic [mrh_pkg::NB_BITS-1:0]     idx_r, idx_nxt, idx_inc;
  logic [mrh_pkg::FRAC_W-1:0]      frac_r, frac_nxt;

  logic                            pix_fire;
  logic                            total_clr;
  logic                            pipe_busy;
  logic [mrh_pkg::COUNT_BITS-1:0]  total;
  mrh_pkg::bin_req_t               req;

  logic                            ram_we;
  logic [mrh_pkg::BIN_BITS-1:0]    ram_waddr;
  logic [mrh_pkg::COUNT_BITS-1:0]  ram_wdata;
  logic [mrh_pkg::BIN_BITS-1:0]    ram_raddr;
  logic [mrh_pkg::COUNT_BITS-1:0]  ram_rdata;

  logic                            rmw_vld_r;
  logic [mrh_pkg::BIN_BITS-1:0]    rmw_idx_r;
  logic                            wr_vld_r;
  logic [mrh_pkg::BIN_BITS-1:0]    wr_idx_r;
  logic [mrh_pkg::COUNT_BITS-1:0]  wr_data_r;
  logic [mrh_pkg::COUNT_BITS-1:0]  cnt_base, cnt_inc;

  logic                            div_start;
  mrh_pkg::frac_res_t              div_res;

  logic                            out_load;
  logic                            out_free;
  logic                            out_valid_r;
  logic [mrh_pkg::OUT_IDX_W-1:0]   out_bin_index_r;
  logic [mrh_pkg::FRAC_W-1:0]      out_fraction_r;
  logic                            out_empty_res_r;
  logic                            out_last_r;

  // ---------------------------------------------------------------
  // Binning pipeline (label match, range check, total, bin divide)
  // ---------------------------------------------------------------
  assign in_ready = (state_r == mrh_pkg::ST_PIX);
  assign pix_fire = in_valid && in_ready && (in_kind == mrh_pkg::KIND_PIXEL);

  mrh_bin_pipe u_bin_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_fire     (pix_fire),
    .pixel_value  (in_pixel_value),
    .pixel_label  (in_pixel_label),
    .n_eff        (n_eff),
    .range_max    (range_max_r),
    .target_label (target_label_r),
    .total_clr    (total_clr),
    .req          (req),
    .busy         (pipe_busy),
    .total        (total)
  );

  // ---------------------------------------------------------------
  // Bin count store
  // ---------------------------------------------------------------
  mrh_ram #(
    .WIDTH (mrh_pkg::COUNT_BITS),
    .DEPTH (mrh_pkg::MAX_BINS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read-modify-write: read issued when the request leaves the pipeline,
  // increment and write in the next cycle. The RAM returns old data on a
  // same-cycle write, so a back-to-back hit on the same bin takes the
  // value written in the previous cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmw_vld_r <= 1'b0;
      wr_vld_r  <= 1'b0;
    end else begin
      rmw_vld_r <= req.vld;
      wr_vld_r  <= rmw_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rmw_idx_r <= req.idx;
    if (rmw_vld_r) begin
      wr_idx_r  <= rmw_idx_r;
      wr_data_r <= cnt_inc;
    end
  end

  always_comb begin
    cnt_base = (wr_vld_r && (wr_idx_r == rmw_idx_r)) ? wr_data_r : ram_rdata;
    cnt_inc  = cnt_base + mrh_pkg::COUNT_BITS'(1);
  end

  // ---------------------------------------------------------------
  // Fraction divider
  // ---------------------------------------------------------------
  mrh_frac_div u_frac_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ram_rdata),
    .divisor  (total),
    .res      (div_res)
  );

  // ---------------------------------------------------------------
  // Sequencer: post-reset sweep, pixel mode, finish walk
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrh_pkg::ST_CLR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_nxt;
  end

  assign idx_inc  = idx_r + mrh_pkg::NB_BITS'(1);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    frac_nxt  = frac_r;
    total_clr = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    // pixel path owns the RAM unless the walk overrides
    ram_raddr = req.idx;
    ram_we    = rmw_vld_r;
    ram_waddr = rmw_idx_r;
    ram_wdata = cnt_inc;

    case (state_r)
      mrh_pkg::ST_PIX: begin
        if (in_valid && in_ready && (in_kind == mrh_pkg::KIND_FINISH)) begin
          state_nxt = mrh_pkg::ST_DRAIN;
        end
      end

      mrh_pkg::ST_DRAIN: begin
        // wait for all in-flight pixel updates to land
        if (!pipe_busy && !rmw_vld_r) begin
          state_nxt = mrh_pkg::ST_RD;
          idx_nxt   = '0;
        end
      end

      mrh_pkg::ST_RD: begin
        ram_raddr = idx_r[mrh_pkg::BIN_BITS-1:0];
        state_nxt = mrh_pkg::ST_LOAD;
      end

      mrh_pkg::ST_LOAD: begin
        // count is on the read port; clear the entry behind it
        ram_we    = 1'b1;
        ram_waddr = idx_r[mrh_pkg::BIN_BITS-1:0];
        ram_wdata = '0;
        if (total == '0) begin
          frac_nxt  = '0;
          state_nxt = mrh_pkg::ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = mrh_pkg::ST_DIV;
        end
      end

      mrh_pkg::ST_DIV: begin
        if (div_res.done) begin
          frac_nxt  = div_res.quot;
          state_nxt = mrh_pkg::ST_OUT;
        end
      end

      mrh_pkg::ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          idx_nxt  = idx_inc;
          if (idx_inc < n_eff) begin
            state_nxt = mrh_pkg::ST_RD;
          end else if (32'(idx_inc) < mrh_pkg::MAX_BINS) begin
            state_nxt = mrh_pkg::ST_CLR;
          end else begin
            state_nxt = mrh_pkg::ST_PIX;
            total_clr = 1'b1;
          end
        end
      end

      mrh_pkg::ST_CLR: begin
        // zero bins beyond those reported (whole store after reset)
        ram_we    = 1'b1;
        ram_waddr = idx_r[mrh_pkg::BIN_BITS-1:0];
        ram_wdata = '0;
        idx_nxt   = idx_inc;
        if (idx_r == mrh_pkg::NB_BITS'(mrh_pkg::MAX_BINS - 1)) begin
          state_nxt = mrh_pkg::ST_PIX;
          total_clr = 1'b1;
        end
      end

      default: begin
        state_nxt = mrh_pkg::ST_CLR;
        idx_nxt   = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_index_r <= mrh_pkg::OUT_IDX_W'(idx_r);
      out_fraction_r  <= frac_r;
      out_empty_res_r <= (total == '0);
      out_last_r      <= (idx_inc == n_eff);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_index = out_bin_index_r;
  assign out_fraction  = out_fraction_r;
  assign out_empty_res = out_empty_res_r;
  assign out_last      = out_last_r;

endmodule

// ----- rtl/core/mrh_checker.sv -----
// Port-level checks for the masked region histogram, bound to the top level.
module mrh_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_kind,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [mrh_pkg::OUT_IDX_W-1:0]   out_bin_index,
  input logic [mrh_pkg::FRAC_W-1:0]      out_fraction,
  input logic                            out_empty_res,
  input logic                            out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin_index)
      && $stable(out_fraction) && $stable(out_empty_res) && $stable(out_last))
    else $error("result changed while stalled");

  // empty histogram reports zero shares
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_fraction == '0)
    else $error("empty result with nonzero fraction");

  // a share never exceeds one
  a_frac_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fraction <= mrh_pkg::FRAC_W'(1 << mrh_pkg::FRAC_BITS))
    else $error("fraction above one");

  // finish stops intake until the walk completes
  a_finish_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == mrh_pkg::KIND_FINISH) |=> !in_ready)
    else $error("input taken right after finish");

  // while pixels are taken, only the final bin of a run can be pending
  a_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("pixel intake while a run is still emitting");

endmodule

bind masked_region_histogram mrh_checker u_mrh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_kind       (in_kind),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_bin_index (out_bin_index),
  .out_fraction  (out_fraction),
  .out_empty_res (out_empty_res),
  .out_last      (out_last)
);
